@@ src/ppu_register_and_scroll_timing_macros.svh @@
// Assertion macros for the video register block.
`ifndef PPU_REGISTER_AND_SCROLL_TIMING_MACROS_SVH
`define PPU_REGISTER_AND_SCROLL_TIMING_MACROS_SVH

`ifndef SYNTHESIS

`define PPURST_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`define PPURST_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define PPURST_ASSERT_IMP(label, ante, cons)

`define PPURST_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ src/ppurst_pkg.sv @@
package ppurst_pkg;

	localparam int SPRITE_BYTES_DEF = 256;

	// item commands
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_DMA   = 2'd3;

	// register ports
	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_MASK   = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_SPADDR = 3'd3;
	localparam logic [2:0] REG_SPDATA = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	// bit positions
	localparam int CTRL_NMI_EN = 7;
	localparam int CTRL_INC32  = 2;
	localparam int MASK_BG     = 3;
	localparam int MASK_SPR    = 4;
	localparam int FLAG_VBLANK = 2;

	localparam logic [2:0]  FLAGS_RESET = 3'b101;
	localparam logic [8:0]  LAST_DOT    = 9'd340;
	localparam logic [8:0]  LAST_LINE   = 9'd261;
	localparam logic [8:0]  VBLANK_LINE = 9'd241;
	localparam logic [8:0]  VISIBLE_END = 9'd240;
	localparam logic [4:0]  COARSE_Y_LAST = 5'd29;
	localparam logic [14:0] HORI_MASK   = 15'h041F;
	localparam logic [14:0] VERT_MASK   = 15'h7BE0;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] vram_read_data;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        nmi;
		logic        dma_start;
		logic [7:0]  dma_page;
		logic        vram_write_en;
		logic        vram_read_en;
		logic [13:0] vram_addr;
		logic [7:0]  vram_write_data;
		logic [8:0]  scanline_out;
		logic [8:0]  dot_out;
	} result_t;

endpackage

@@ src/ppurst_item_if.sv @@
interface ppurst_item_if;
	logic                 valid;
	logic                 ready;
	ppurst_pkg::item_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/ppurst_result_if.sv @@
interface ppurst_result_if;
	logic                 valid;
	logic                 ready;
	ppurst_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/ppu_register_and_scroll_timing.sv @@
// channel | dir | payload                                   | handshake
// item    | in  | cmd, reg_index, write_data, vram_read_data | valid/ready
// result  | out | read_data, nmi, dma, vram_*, line/dot      | valid/ready
//
// One request per cycle unless the output stalls; results pass through the stages
// (stage 1: decoded result and sprite-store read, stage 2: output register).
// Sprite store is a 256-byte synchronous RAM; its registered read is resolved in
// stage 1, and open bus is forwarded from that read to the next request.
// Reset clears state registers (flags load FLAGS_RESET) and sprite store valid bits.
// A stalled output holds stage 1; input ready drops only when both stages are full.
`include "ppu_register_and_scroll_timing_macros.svh"

module ppu_register_and_scroll_timing #(
	parameter int SPRITE_BYTES = ppurst_pkg::SPRITE_BYTES_DEF
) (
	input logic              clk,
	input logic              arst_n,
	ppurst_item_if.sink      item,
	ppurst_result_if.source  result
);

	localparam int AW = $clog2(SPRITE_BYTES);

	// architectural state
	logic [7:0]  ctrl_q, mask_q, rbuf_q, open_bus_q, spr_addr_q;
	logic [2:0]  flags_q;
	logic [14:0] v_q, t_q;
	logic        toggle_q, nmi_pend_q;
	logic [8:0]  dot_q, line_q;

	// sprite store
	logic [7:0]              spr_mem [SPRITE_BYTES];
	logic [SPRITE_BYTES-1:0] spr_vld_q;
	logic [AW-1:0]           spr_idx;
	logic                    spr_wr, spr_rd;

	// pipeline
	logic                valid_s1, valid_s2;
	logic                spr_rd_s1, spr_hit_s1;
	logic [7:0]          spr_rdata_s1;
	ppurst_pkg::result_t res_s1, res_s2, res_s2_n;
	logic                s1_adv, acc;
	logic [7:0]          spr_data, ob_eff;

	// next state
	ppurst_pkg::item_t   d;
	ppurst_pkg::result_t res;
	logic [7:0]  ctrl_n, mask_n, rbuf_n, ob_n, sa_n;
	logic [2:0]  flags_n;
	logic [14:0] v_n, t_n, v_step, v_scr;
	logic        tog_n, np_n, rendering, addr_hit;
	logic [8:0]  dot_n, line_n;

	function automatic logic [14:0] cx_inc(input logic [14:0] v);
		logic [14:0] r;
		r = v;
		r[4:0] = v[4:0] + 5'd1;
		if (v[4:0] == 5'd31)
			r[10] = ~v[10];
		return r;
	endfunction

	function automatic logic [14:0] y_inc(input logic [14:0] v);
		logic [14:0] r;
		r = v;
		if (v[14:12] != 3'd7) begin
			r[14:12] = v[14:12] + 3'd1;
		end else begin
			r[14:12] = 3'd0;
			if (v[9:5] == ppurst_pkg::COARSE_Y_LAST) begin
				r[9:5] = 5'd0;
				r[11] = ~v[11];
			end else begin
				r[9:5] = v[9:5] + 5'd1;
			end
		end
		return r;
	endfunction

	assign d = item.data;
	assign s1_adv = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || s1_adv;
	assign acc = item.valid && item.ready;
	assign result.valid = valid_s2;
	assign result.data = res_s2;

	assign spr_idx = spr_addr_q[AW-1:0];
	assign spr_data = spr_hit_s1 ? spr_rdata_s1 : 8'd0;
	// open bus as seen by the next request: a sprite read in stage 1 owns it
	assign ob_eff = (valid_s1 && spr_rd_s1) ? spr_data : open_bus_q;
	assign rendering = mask_q[ppurst_pkg::MASK_BG] || mask_q[ppurst_pkg::MASK_SPR];
	assign v_step = v_q + (ctrl_q[ppurst_pkg::CTRL_INC32] ? 15'd32 : 15'd1);
	assign spr_wr = acc && d.cmd == ppurst_pkg::CMD_WRITE && d.reg_index == ppurst_pkg::REG_SPDATA;
	assign spr_rd = acc && d.cmd == ppurst_pkg::CMD_READ && d.reg_index == ppurst_pkg::REG_SPDATA;

	// scroll counter steps for a tick
	always_comb begin
		logic vis, fetch;
		vis = (line_q < ppurst_pkg::VISIBLE_END) || (line_q == ppurst_pkg::LAST_LINE);
		fetch = (dot_q > 9'd0 && dot_q < 9'd257) || (dot_q > 9'd320 && dot_q < 9'd337);
		v_scr = v_q;
		if (vis && fetch && dot_q[2:0] == 3'd0)
			v_scr = cx_inc(v_scr);
		if (vis && fetch && dot_q == 9'd256)
			v_scr = y_inc(v_scr);
		if (vis && dot_q == 9'd257)
			v_scr = (v_scr & ~ppurst_pkg::HORI_MASK) | (t_q & ppurst_pkg::HORI_MASK);
		if (line_q == ppurst_pkg::LAST_LINE && dot_q > 9'd279 && dot_q < 9'd305)
			v_scr = (v_scr & ~ppurst_pkg::VERT_MASK) | (t_q & ppurst_pkg::VERT_MASK);
	end

	always_comb begin
		ctrl_n = ctrl_q;
		mask_n = mask_q;
		flags_n = flags_q;
		v_n = v_q;
		t_n = t_q;
		tog_n = toggle_q;
		sa_n = spr_addr_q;
		rbuf_n = rbuf_q;
		ob_n = ob_eff;
		dot_n = dot_q;
		line_n = line_q;
		np_n = nmi_pend_q;
		res = '0;
		addr_hit = 1'b0;
		case (d.cmd)
			ppurst_pkg::CMD_TICK: begin
				res.nmi = nmi_pend_q;
				if (rendering)
					v_n = v_scr;
				if (line_q == ppurst_pkg::VBLANK_LINE && dot_q == 9'd1) begin
					flags_n[ppurst_pkg::FLAG_VBLANK] = 1'b1;
					res.nmi = res.nmi || ctrl_q[ppurst_pkg::CTRL_NMI_EN];
				end
				if (line_q == ppurst_pkg::LAST_LINE && dot_q == 9'd1)
					flags_n = 3'd0;
				if (dot_q >= ppurst_pkg::LAST_DOT) begin
					dot_n = 9'd0;
					line_n = (line_q >= ppurst_pkg::LAST_LINE) ? 9'd0 : line_q + 9'd1;
				end else begin
					dot_n = dot_q + 9'd1;
				end
				np_n = 1'b0;
			end
			ppurst_pkg::CMD_READ: begin
				case (d.reg_index)
					ppurst_pkg::REG_STATUS: begin
						ob_n = {flags_q, ob_eff[4:0]};
						tog_n = 1'b0;
						flags_n[ppurst_pkg::FLAG_VBLANK] = 1'b0;
						np_n = 1'b0;
					end
					ppurst_pkg::REG_DATA: begin
						ob_n = rbuf_q;
						rbuf_n = d.vram_read_data;
						res.vram_read_en = 1'b1;
						addr_hit = 1'b1;
						v_n = v_step;
					end
					default: begin
						// write-only ports; sprite data is filled in at stage 1
					end
				endcase
			end
			ppurst_pkg::CMD_WRITE: begin
				ob_n = d.write_data;
				case (d.reg_index)
					ppurst_pkg::REG_CTRL: begin
						ctrl_n = d.write_data;
						t_n[11:10] = d.write_data[1:0];
						np_n = d.write_data[ppurst_pkg::CTRL_NMI_EN]
							&& flags_q[ppurst_pkg::FLAG_VBLANK];
					end
					ppurst_pkg::REG_MASK: mask_n = d.write_data;
					ppurst_pkg::REG_SPADDR: sa_n = d.write_data;
					ppurst_pkg::REG_SPDATA: sa_n = spr_addr_q + 8'd1;
					ppurst_pkg::REG_SCROLL: begin
						if (toggle_q) begin
							t_n[14:12] = d.write_data[2:0];
							t_n[9:5] = d.write_data[7:3];
						end else begin
							t_n[4:0] = d.write_data[7:3];
						end
						tog_n = !toggle_q;
					end
					ppurst_pkg::REG_ADDR: begin
						if (!toggle_q) begin
							t_n[14:8] = {1'b0, d.write_data[5:0]};
						end else begin
							t_n[7:0] = d.write_data;
							v_n = {t_q[14:8], d.write_data};
						end
						tog_n = !toggle_q;
					end
					ppurst_pkg::REG_DATA: begin
						addr_hit = 1'b1;
						if (!rendering) begin
							res.vram_write_en = 1'b1;
							res.vram_write_data = d.write_data;
						end
						v_n = v_step;
					end
					default: begin
						// status port: open bus only
					end
				endcase
			end
			default: begin
				res.dma_start = 1'b1;
				res.dma_page = d.write_data;
			end
		endcase
		res.read_data = ob_n;
		res.vram_addr = addr_hit ? v_q[13:0] : v_n[13:0];
		res.scanline_out = line_n;
		res.dot_out = dot_n;
	end

	always_comb begin
		res_s2_n = res_s1;
		if (spr_rd_s1)
			res_s2_n.read_data = spr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			mask_q <= '0;
			flags_q <= ppurst_pkg::FLAGS_RESET;
			v_q <= '0;
			t_q <= '0;
			toggle_q <= 1'b0;
			spr_addr_q <= '0;
			rbuf_q <= '0;
			open_bus_q <= '0;
			dot_q <= '0;
			line_q <= '0;
			nmi_pend_q <= 1'b0;
			spr_vld_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				ctrl_q <= ctrl_n;
				mask_q <= mask_n;
				flags_q <= flags_n;
				v_q <= v_n;
				t_q <= t_n;
				toggle_q <= tog_n;
				spr_addr_q <= sa_n;
				rbuf_q <= rbuf_n;
				open_bus_q <= ob_n;
				dot_q <= dot_n;
				line_q <= line_n;
				nmi_pend_q <= np_n;
			end else if (s1_adv && spr_rd_s1) begin
				open_bus_q <= spr_data;
			end
			if (spr_wr)
				spr_vld_q[spr_idx] <= 1'b1;
			if (acc)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
			if (s1_adv)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (spr_wr)
			spr_mem[spr_idx] <= d.write_data;
		if (spr_rd) begin
			spr_rdata_s1 <= spr_mem[spr_idx];
			spr_hit_s1 <= spr_vld_q[spr_idx];
		end
		if (acc) begin
			res_s1 <= res;
			spr_rd_s1 <= spr_rd;
		end
		if (s1_adv)
			res_s2 <= res_s2_n;
	end

	`PPURST_ASSERT_NXT(a_spr_hold, valid_s1 && spr_rd_s1 && !s1_adv, $stable(spr_data))
	`PPURST_ASSERT_NXT(a_vblank_nmi, acc && d.cmd == ppurst_pkg::CMD_TICK && line_q == ppurst_pkg::VBLANK_LINE && dot_q == 9'd1 && ctrl_q[ppurst_pkg::CTRL_NMI_EN], res_s1.nmi)
	`PPURST_ASSERT_NXT(a_dot_wrap, acc && d.cmd == ppurst_pkg::CMD_TICK && dot_q == ppurst_pkg::LAST_DOT, dot_q == 9'd0)
	`PPURST_ASSERT_IMP(a_one_access, result.valid && result.data.vram_write_en, !result.data.vram_read_en && !result.data.dma_start && !result.data.nmi)

endmodule

@@ tb/testbench.sv @@
module testbench;

	logic clk = 1'b0;
	logic arst_n;

	ppurst_item_if item_bus();
	ppurst_result_if result_bus();

	ppu_register_and_scroll_timing u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the picture unit state
	logic [7:0]  ppu_ctrl = '0;
	logic [7:0]  ppu_mask = '0;
	logic [7:0]  ppu_flags = 8'hA0;
	logic [14:0] ppu_v = '0;
	logic [14:0] ppu_t = '0;
	logic [2:0]  ppu_fine_x = '0;
	logic        ppu_toggle = 1'b0;
	logic [7:0]  oam_addr = '0;
	logic [7:0]  oam_bytes [ppurst_pkg::SPRITE_BYTES_DEF];
	logic [7:0]  data_buf = '0;
	logic [7:0]  bus_latch = '0;
	logic [8:0]  ppu_dot = '0;
	logic [8:0]  ppu_line = '0;
	logic        odd_frame = 1'b0;
	logic        nmi_armed = 1'b0;

	ppurst_pkg::result_t ppu_replies_q [$];
	int      mismatch_cnt = 0;
	int      fail_cnt = 0;
	int      req_count = 0;
	bit      no_stall = 1'b0;

	function automatic logic rendering_on();
		return ppu_mask[ppurst_pkg::MASK_BG] | ppu_mask[ppurst_pkg::MASK_SPR];
	endfunction

	function automatic void rearm_nmi();
		nmi_armed = ppu_ctrl[ppurst_pkg::CTRL_NMI_EN] & ppu_flags[7];
	endfunction

	function automatic void bump_v();
		ppu_v = ppu_v + (ppu_ctrl[ppurst_pkg::CTRL_INC32] ? 15'd32 : 15'd1);
	endfunction

	function automatic void coarse_x_inc();
		ppu_v[4:0] = ppu_v[4:0] + 5'd1;
		if (ppu_v[4:0] == 5'd0)
			ppu_v[10] = ~ppu_v[10];
	endfunction

	function automatic void fine_y_inc();
		ppu_v[14:12] = ppu_v[14:12] + 3'd1;
		if (ppu_v[14:12] == 3'd0) begin
			// coarse y wraps at 30 with a nametable flip, at 32 without
			ppu_v[9:5] = ppu_v[9:5] + 5'd1;
			if (ppu_v[9:5] == 5'd30) begin
				ppu_v[9:5] = 5'd0;
				ppu_v[11] = ~ppu_v[11];
			end
		end
	endfunction

	function automatic void scroll_step();
		if (!(ppu_line < ppurst_pkg::VISIBLE_END || ppu_line == ppurst_pkg::LAST_LINE))
			return;
		if ((ppu_dot > 0 && ppu_dot < 257) || (ppu_dot > 320 && ppu_dot < 337)) begin
			if (ppu_dot[2:0] == 3'd0)
				coarse_x_inc();
			if (ppu_dot == 9'd256)
				fine_y_inc();
		end else if (ppu_dot == 9'd257) begin
			ppu_v = (ppu_v & ~ppurst_pkg::HORI_MASK) | (ppu_t & ppurst_pkg::HORI_MASK);
		end
		if (ppu_line == ppurst_pkg::LAST_LINE && ppu_dot > 279 && ppu_dot < 305)
			ppu_v = (ppu_v & ~ppurst_pkg::VERT_MASK) | (ppu_t & ppurst_pkg::VERT_MASK);
	endfunction

	function automatic ppurst_pkg::result_t ppu_apply_item(input ppurst_pkg::item_t it);
		ppurst_pkg::result_t r;
		logic    touched;
		r = '0;
		touched = 1'b0;
		case (it.cmd)
			ppurst_pkg::CMD_TICK: begin
				r.nmi = nmi_armed;
				if (rendering_on())
					scroll_step();
				if (ppu_line == ppurst_pkg::VBLANK_LINE && ppu_dot == 9'd1) begin
					ppu_flags[7] = 1'b1;
					rearm_nmi();
					r.nmi = r.nmi | nmi_armed;
				end
				if (ppu_line == ppurst_pkg::LAST_LINE && ppu_dot == 9'd1) begin
					ppu_flags = '0;
					rearm_nmi();
					r.nmi = r.nmi | nmi_armed;
				end
				if (ppu_dot == ppurst_pkg::LAST_DOT) begin
					ppu_dot = '0;
					if (ppu_line == ppurst_pkg::LAST_LINE) begin
						ppu_line = '0;
						odd_frame = ~odd_frame;
					end else begin
						ppu_line = ppu_line + 9'd1;
					end
				end else begin
					ppu_dot = ppu_dot + 9'd1;
				end
				nmi_armed = 1'b0;
				r.read_data = bus_latch;
			end
			ppurst_pkg::CMD_READ: begin
				case (it.reg_index)
					ppurst_pkg::REG_STATUS: begin
						bus_latch = (ppu_flags & 8'hE0) | (bus_latch & 8'h1F);
						ppu_toggle = 1'b0;
						ppu_flags[7] = 1'b0;
						rearm_nmi();
					end
					ppurst_pkg::REG_SPDATA: bus_latch = oam_bytes[oam_addr];
					ppurst_pkg::REG_DATA: begin
						bus_latch = data_buf;
						data_buf = it.vram_read_data;
						r.vram_read_en = 1'b1;
						r.vram_addr = ppu_v[13:0];
						touched = 1'b1;
						bump_v();
					end
					default: ;
				endcase
				r.read_data = bus_latch;
			end
			ppurst_pkg::CMD_WRITE: begin
				case (it.reg_index)
					ppurst_pkg::REG_CTRL: begin
						ppu_ctrl = it.write_data;
						ppu_t[11:10] = it.write_data[1:0];
						rearm_nmi();
					end
					ppurst_pkg::REG_MASK: ppu_mask = it.write_data;
					ppurst_pkg::REG_STATUS: ;
					ppurst_pkg::REG_SPADDR: oam_addr = it.write_data;
					ppurst_pkg::REG_SPDATA: begin
						oam_bytes[oam_addr] = it.write_data;
						oam_addr = oam_addr + 8'd1;
					end
					ppurst_pkg::REG_SCROLL: begin
						if (ppu_toggle) begin
							ppu_t[14:12] = it.write_data[2:0];
							ppu_t[9:5] = it.write_data[7:3];
						end else begin
							ppu_fine_x = it.write_data[2:0];
							ppu_t[4:0] = it.write_data[7:3];
						end
						ppu_toggle = ~ppu_toggle;
					end
					ppurst_pkg::REG_ADDR: begin
						if (!ppu_toggle) begin
							ppu_t[14:8] = {1'b0, it.write_data[5:0]};
						end else begin
							ppu_t[7:0] = it.write_data;
							ppu_v = ppu_t;
						end
						ppu_toggle = ~ppu_toggle;
					end
					default: begin
						r.vram_addr = ppu_v[13:0];
						touched = 1'b1;
						if (!rendering_on()) begin
							r.vram_write_en = 1'b1;
							r.vram_write_data = it.write_data;
						end
						bump_v();
					end
				endcase
				bus_latch = it.write_data;
				r.read_data = bus_latch;
			end
			default: begin
				r.dma_start = 1'b1;
				r.dma_page = it.write_data;
				r.read_data = bus_latch;
			end
		endcase
		if (!touched)
			r.vram_addr = ppu_v[13:0];
		r.scanline_out = ppu_line;
		r.dot_out = ppu_dot;
		return r;
	endfunction

	always @(posedge clk) begin : reply_check
		ppurst_pkg::result_t want;
		if (arst_n) begin
			if (item_bus.valid && item_bus.ready)
				ppu_replies_q.push_back(ppu_apply_item(item_bus.data));
			if (result_bus.valid && result_bus.ready) begin
				if (ppu_replies_q.size() == 0) begin
					fail_cnt++;
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result: %p", result_bus.data);
				end else begin
					want = ppu_replies_q.pop_front();
					if (result_bus.data !== want) begin
						fail_cnt++;
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("mismatch: exp rd=%h nmi=%b dma=%b pg=%h we=%b re=%b a=%h wd=%h ln=%0d dot=%0d",
								want.read_data, want.nmi, want.dma_start, want.dma_page,
								want.vram_write_en, want.vram_read_en, want.vram_addr,
								want.vram_write_data, want.scanline_out, want.dot_out);
							$display("          got rd=%h nmi=%b dma=%b pg=%h we=%b re=%b a=%h wd=%h ln=%0d dot=%0d",
								result_bus.data.read_data, result_bus.data.nmi,
								result_bus.data.dma_start, result_bus.data.dma_page,
								result_bus.data.vram_write_en, result_bus.data.vram_read_en,
								result_bus.data.vram_addr, result_bus.data.vram_write_data,
								result_bus.data.scanline_out, result_bus.data.dot_out);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		result_bus.ready <= no_stall || ($urandom_range(99) >= 32);
	end

	task automatic send_req(input logic [1:0] c, input logic [2:0] r, input logic [7:0] w,
			input logic [7:0] vd);
		ppurst_pkg::item_t it;
		it.cmd = c;
		it.reg_index = r;
		it.write_data = w;
		it.vram_read_data = vd;
		while (!no_stall && $urandom_range(99) < 32) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.data <= it;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		req_count++;
	endtask

	task automatic drain_replies();
		item_bus.valid <= 1'b0;
		while (ppu_replies_q.size() != 0)
			@(posedge clk);
	endtask

	// one register access of a random kind, biased toward useful values
	task automatic poke_random_port();
		logic [7:0] w;
		w = 8'($urandom);
		case ($urandom_range(10))
			0: send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_CTRL, w, 8'($urandom));
			1: send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_MASK,
				($urandom_range(4) == 0) ? (w & 8'hE7) : (w | 8'h08), 8'($urandom));
			2: send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_STATUS, w, 8'($urandom));
			3: send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SCROLL, w, 8'($urandom));
			4: send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_ADDR, w, 8'($urandom));
			5: send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_DATA, w, 8'($urandom));
			6: send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_DATA, w, 8'($urandom));
			7: send_req(ppurst_pkg::CMD_WRITE,
				$urandom_range(1) ? ppurst_pkg::REG_SPADDR : ppurst_pkg::REG_SPDATA,
				w, 8'($urandom));
			8: send_req(ppurst_pkg::CMD_READ, 3'($urandom_range(7)), w, 8'($urandom));
			9: send_req(ppurst_pkg::CMD_WRITE, 3'($urandom_range(7)), w, 8'($urandom));
			default: send_req(ppurst_pkg::CMD_DMA, 3'($urandom_range(7)), w, 8'($urandom));
		endcase
	endtask

	task automatic test_directed();
		send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_STATUS, 8'h00, 8'h00);
		// enable after a status read has cleared vblank: these writes give no pulse
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_CTRL, 8'hFF, 8'hFF);
		send_req(ppurst_pkg::CMD_TICK, ppurst_pkg::REG_DATA, 8'hFF, 8'hFF);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_CTRL, 8'h80, 8'h00);
		send_req(ppurst_pkg::CMD_TICK, ppurst_pkg::REG_CTRL, 8'h00, 8'h00);
		send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_STATUS, 8'hFF, 8'hFF);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_CTRL, 8'h80, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_CTRL, 8'h00, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_MASK, 8'h00, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SCROLL, 8'hFF, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SCROLL, 8'h00, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_ADDR, 8'hFF, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_ADDR, 8'hFF, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_DATA, 8'hAA, 8'h00);
		send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_DATA, 8'h00, 8'hFF);
		send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_DATA, 8'h00, 8'h00);
		// sprite address wraps from 0xFF to 0x00
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SPADDR, 8'hFF, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SPDATA, 8'h5A, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SPADDR, 8'hFF, 8'h00);
		send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_SPDATA, 8'h00, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_STATUS, 8'h1F, 8'h00);
		send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_CTRL, 8'h00, 8'h00);
		send_req(ppurst_pkg::CMD_DMA, ppurst_pkg::REG_DATA, 8'hFF, 8'hFF);
		// data write while rendering only steps v
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_MASK, 8'h18, 8'h00);
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_DATA, 8'h55, 8'h00);
	endtask

	task automatic test_random_sequences();
		int stop_at;
		int n;
		stop_at = req_count + 950;
		while (req_count < stop_at) begin
			case ($urandom_range(7))
				0, 1: begin
					n = ($urandom_range(9) == 0) ? $urandom_range(400) : $urandom_range(1, 40);
					repeat (n)
						send_req(ppurst_pkg::CMD_TICK, 3'($urandom_range(7)),
							8'($urandom), 8'($urandom));
				end
				2: begin
					send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_STATUS,
						8'($urandom), 8'($urandom));
					send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SCROLL,
						8'($urandom), 8'($urandom));
					send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SCROLL,
						8'($urandom), 8'($urandom));
				end
				3: begin
					send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_STATUS,
						8'($urandom), 8'($urandom));
					send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_ADDR,
						8'($urandom), 8'($urandom));
					send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_ADDR,
						8'($urandom), 8'($urandom));
					repeat ($urandom_range(1, 4))
						send_req($urandom_range(1) ? ppurst_pkg::CMD_READ : ppurst_pkg::CMD_WRITE,
							ppurst_pkg::REG_DATA, 8'($urandom), 8'($urandom));
				end
				4: begin
					n = $urandom;
					send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SPADDR, 8'(n), 8'($urandom));
					repeat ($urandom_range(1, 4))
						send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SPDATA,
							8'($urandom), 8'($urandom));
					send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_SPADDR, 8'(n), 8'($urandom));
					send_req(ppurst_pkg::CMD_READ, ppurst_pkg::REG_SPDATA,
						8'($urandom), 8'($urandom));
				end
				5: poke_random_port();
				6: send_req(2'($urandom_range(3)), 3'($urandom_range(7)),
					8'($urandom), 8'($urandom));
				default: send_req(ppurst_pkg::CMD_WRITE,
					$urandom_range(1) ? ppurst_pkg::REG_CTRL : ppurst_pkg::REG_MASK,
					8'($urandom), 8'($urandom));
			endcase
		end
	endtask

	// just under two scanlines of ticks with rendering on: coarse x, the y step, the horizontal copy
	// and the line wrap
	task automatic test_frame_sweep();
		int ticks;
		bit busy_zone;
		send_req(ppurst_pkg::CMD_WRITE, ppurst_pkg::REG_MASK, 8'h18, 8'($urandom));
		for (ticks = 0; ticks < 680; ticks++) begin
			no_stall = (ticks >= 200 && ticks < 500);
			busy_zone = (ppu_dot >= 9'd250 && ppu_dot <= 9'd262) || ppu_dot >= 9'd335;
			if ($urandom_range(999) < (busy_zone ? 40 : 8))
				poke_random_port();
			send_req(ppurst_pkg::CMD_TICK, 3'($urandom_range(7)), 8'($urandom), 8'($urandom));
		end
		no_stall = 1'b0;
	endtask

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		foreach (oam_bytes[i])
			oam_bytes[i] = '0;
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.data = '0;
		result_bus.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain_replies();
		test_random_sequences();
		drain_replies();
		test_frame_sweep();
		drain_replies();
		repeat (10) @(posedge clk);

		if (fail_cnt == 0 && ppu_replies_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+src
src/ppurst_pkg.sv
src/ppurst_item_if.sv
src/ppurst_result_if.sv
src/ppu_register_and_scroll_timing.sv
tb/testbench.sv
